@@ rtl/pidm_pkg.sv @@
package pidm_pkg;

  // field widths
  localparam int unsigned CmdWidth     = 8;
  localparam int unsigned CountWidth   = 16;
  localparam int unsigned GainWidth    = 16;
  localparam int unsigned LimitWidth   = 10;
  localparam int unsigned BandWidth    = 8;
  localparam int unsigned DutyWidth    = 10;
  localparam int unsigned DirWidth     = 2;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  // integral width, at least ErrWidth
  localparam int unsigned SumWidth   = 24;
  localparam int unsigned ErrWidth   = 9;
  localparam int unsigned DerivWidth = ErrWidth + 1;
  localparam int unsigned AccWidth   = SumWidth + GainWidth + 3;

  // angle scaling
  localparam int unsigned TargetScale  = 90;
  localparam int unsigned ScaledWidth  = 15;
  localparam int unsigned TargetWidth  = 7;
  localparam int unsigned ActualWidth  = 8;

  // Q8.8 fraction bits
  localparam int unsigned FracBits = 8;

  // register reset values
  localparam logic [GainWidth-1:0]  GainPReset    = 16'd3840;
  localparam logic [GainWidth-1:0]  GainIReset    = 16'd128;
  localparam logic [GainWidth-1:0]  GainDReset    = 16'd128;
  localparam logic [LimitWidth-1:0] PwmLimitReset = 10'd625;
  localparam logic [BandWidth-1:0]  DeadbandReset = 8'd1;

  typedef enum logic [DirWidth-1:0] {
    DirStop = 2'd0,
    DirFwd  = 2'd1,
    DirRev  = 2'd2
  } dir_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegGainP    = 3'd0,
    RegGainI    = 3'd1,
    RegGainD    = 3'd2,
    RegPwmLimit = 3'd3,
    RegDeadband = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [GainWidth-1:0]  gain_p;
    logic [GainWidth-1:0]  gain_i;
    logic [GainWidth-1:0]  gain_d;
    logic [LimitWidth-1:0] pwm_limit;
    logic [BandWidth-1:0]  deadband;
  } cfg_t;

  typedef struct packed {
    logic                       valid;
    logic signed [ErrWidth-1:0] err;
  } front_t;

endpackage

@@ rtl/pidm_in_if.sv @@
interface pidm_in_if;
  logic                            valid;
  logic                            ready;
  logic [pidm_pkg::CmdWidth-1:0]   command_byte;
  logic [pidm_pkg::CountWidth-1:0] encoder_count;

  modport source (output valid, command_byte, encoder_count, input ready);
  modport sink   (input valid, command_byte, encoder_count, output ready);
endinterface

@@ rtl/pidm_out_if.sv @@
interface pidm_out_if;
  logic                           valid;
  logic                           ready;
  logic [pidm_pkg::DutyWidth-1:0] duty;
  logic [pidm_pkg::DirWidth-1:0]  drive_dir;

  modport source (output valid, duty, drive_dir, input ready);
  modport sink   (input valid, duty, drive_dir, output ready);
endinterface

@@ rtl/pidm_cfg_if.sv @@
interface pidm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pidm_pkg::CfgIdxWidth-1:0]  index;
  logic [pidm_pkg::CfgDataWidth-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/pidm_cfg_regs.sv @@
module pidm_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  pidm_cfg_if.sink         cfg_i,
  output pidm_pkg::cfg_t   cfg_o
);

  pidm_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pidm_pkg::RegGainP:    cfg_d.gain_p    = cfg_i.data[pidm_pkg::GainWidth-1:0];
        pidm_pkg::RegGainI:    cfg_d.gain_i    = cfg_i.data[pidm_pkg::GainWidth-1:0];
        pidm_pkg::RegGainD:    cfg_d.gain_d    = cfg_i.data[pidm_pkg::GainWidth-1:0];
        pidm_pkg::RegPwmLimit: cfg_d.pwm_limit = cfg_i.data[pidm_pkg::LimitWidth-1:0];
        pidm_pkg::RegDeadband: cfg_d.deadband  = cfg_i.data[pidm_pkg::BandWidth-1:0];
        default:               cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= pidm_pkg::GainPReset;
      cfg_q.gain_i    <= pidm_pkg::GainIReset;
      cfg_q.gain_d    <= pidm_pkg::GainDReset;
      cfg_q.pwm_limit <= pidm_pkg::PwmLimitReset;
      cfg_q.deadband  <= pidm_pkg::DeadbandReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/pidm_front.sv @@
module pidm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  pidm_in_if.sink           in_i,
  input  logic              take_i,
  output pidm_pkg::front_t  front_o
);

  logic [pidm_pkg::ScaledWidth-1:0]   scaled;
  logic [pidm_pkg::TargetWidth-1:0]   tgt_lo;
  logic [pidm_pkg::TargetWidth:0]     tgt_hi;
  logic [pidm_pkg::ScaledWidth:0]     tgt_back;
  logic [pidm_pkg::TargetWidth-1:0]   target;
  logic [pidm_pkg::ActualWidth-1:0]   act_hi;
  logic [pidm_pkg::CountWidth:0]      act_back;
  logic [pidm_pkg::ActualWidth-1:0]   actual;
  logic signed [pidm_pkg::ErrWidth-1:0] err;
  logic                               accept;
  logic                               valid_q, valid_d;
  logic signed [pidm_pkg::ErrWidth-1:0] err_q;

  // target = cmd*90/255: divide by 256, then step up by one if it still fits
  always_comb begin
    scaled   = pidm_pkg::ScaledWidth'(in_i.command_byte) *
               pidm_pkg::ScaledWidth'(pidm_pkg::TargetScale);
    tgt_lo   = scaled[pidm_pkg::ScaledWidth-1:pidm_pkg::FracBits];
    tgt_hi   = {1'b0, tgt_lo} + 1'b1;
    tgt_back = {tgt_hi, 8'd0} - (pidm_pkg::ScaledWidth+1)'(tgt_hi);
    target   = (tgt_back <= {1'b0, scaled}) ? tgt_hi[pidm_pkg::TargetWidth-1:0] : tgt_lo;
  end

  // actual = count/257: divide by 256, then step down by one if too large
  always_comb begin
    act_hi   = in_i.encoder_count[pidm_pkg::CountWidth-1:pidm_pkg::FracBits];
    act_back = {1'b0, act_hi, 8'd0} + (pidm_pkg::CountWidth+1)'(act_hi);
    actual   = (act_back > {1'b0, in_i.encoder_count}) ? act_hi - 1'b1 : act_hi;
    err      = $signed({2'b00, target}) - $signed({1'b0, actual});
  end

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;
  assign valid_d    = accept || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q <= err;
    end
  end

  assign front_o.valid = valid_q;
  assign front_o.err   = err_q;

endmodule

@@ rtl/pidm_core.sv @@
module pidm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pidm_pkg::front_t  front_i,
  input  pidm_pkg::cfg_t    cfg_i,
  output logic              take_o,
  pidm_out_if.source        res_o
);

  localparam int unsigned SW = pidm_pkg::SumWidth;
  localparam int unsigned EW = pidm_pkg::ErrWidth;
  localparam int unsigned AW = pidm_pkg::AccWidth;
  localparam int unsigned GW = pidm_pkg::GainWidth;
  localparam int unsigned LW = pidm_pkg::LimitWidth;
  localparam int unsigned FB = pidm_pkg::FracBits;

  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [EW-1:0] last_q;
  logic                 res_valid_q, res_valid_d;
  logic [pidm_pkg::DutyWidth-1:0] duty_q, duty_d;
  pidm_pkg::dir_e       dir_q, dir_d;

  logic signed [SW:0]   sum_wide;
  logic signed [SW-1:0] sum_sat;
  logic signed [pidm_pkg::DerivWidth-1:0] deriv;
  logic signed [GW+EW:0]                  p_prod;
  logic signed [GW+SW:0]                  i_prod;
  logic signed [GW+pidm_pkg::DerivWidth:0] d_prod;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] lim;
  logic signed [AW-1:0] clamped;
  logic signed [AW-1:0] mag_out;
  logic [EW-1:0]        mag_err;
  logic                 drive;

  assign take_o = front_i.valid && (!res_valid_q || res_o.ready);

  always_comb begin
    // saturating integral
    sum_wide = {sum_q[SW-1], sum_q} + {{(SW+1-EW){front_i.err[EW-1]}}, front_i.err};
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end

    deriv  = pidm_pkg::DerivWidth'(front_i.err) - pidm_pkg::DerivWidth'(last_q);
    p_prod = $signed({1'b0, cfg_i.gain_p}) * front_i.err;
    i_prod = $signed({1'b0, cfg_i.gain_i}) * sum_sat;
    d_prod = $signed({1'b0, cfg_i.gain_d}) * deriv;
    acc    = AW'(p_prod) + AW'(i_prod) + AW'(d_prod);

    // clamp to +/- limit in Q8.8
    lim = $signed(AW'({cfg_i.pwm_limit, {FB{1'b0}}}));
    if (acc > lim) begin
      clamped = lim;
    end else if (acc < -lim) begin
      clamped = -lim;
    end else begin
      clamped = acc;
    end

    mag_err = front_i.err[EW-1] ? EW'(-front_i.err) : EW'(front_i.err);
    drive   = mag_err > EW'(cfg_i.deadband);

    mag_out = (clamped > 0) ? clamped : -clamped;
    if (drive) begin
      dir_d  = (clamped > 0) ? pidm_pkg::DirFwd : pidm_pkg::DirRev;
      duty_d = mag_out[LW+FB-1:FB];
      sum_d  = sum_sat;
    end else begin
      dir_d  = pidm_pkg::DirStop;
      duty_d = '0;
      sum_d  = '0;
    end
  end

  assign res_valid_d = take_o || (res_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      sum_q       <= '0;
      last_q      <= '0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take_o) begin
        sum_q  <= sum_d;
        last_q <= front_i.err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      duty_q <= duty_d;
      dir_q  <= dir_d;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.duty      = duty_q;
  assign res_o.drive_dir = dir_q;

endmodule

@@ rtl/pid_position_motor_drive.sv @@
// pid position controller, one control tick per request
// stages: error register, then result register
// one request per cycle unless stalled, the integral and last error loop closes in the pid stage
// while a result waits, the error register holds one more request, then the input stalls
// reset (async, active low): gains 15.0/0.5/0.5, limit 625, deadband 1,
// integral and last error zero, pipeline empty
module pid_position_motor_drive (
  input  logic       clk_i,
  input  logic       rst_ni,
  pidm_cfg_if.sink   cfg_i,
  pidm_in_if.sink    in_i,
  pidm_out_if.source res_o
);

  pidm_pkg::cfg_t   cfg;
  pidm_pkg::front_t front;
  logic             take;

  // register file: the user writes only while no request is in flight; not enforced
  pidm_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // scale command and encoder to degrees, register the position error
  pidm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .front_o (front)
  );

  // integral, derivative, gain sum, clamp and direction into the result register
  pidm_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .front_i (front),
    .cfg_i   (cfg),
    .take_o  (take),
    .res_o   (res_o)
  );

endmodule

@@ rtl/pidm_checker.sv @@
module pidm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [pidm_pkg::DutyWidth-1:0] duty_i,
  input logic [pidm_pkg::DirWidth-1:0]  drive_dir_i
);

  // a pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(duty_i) && $stable(drive_dir_i))
    else $error("result changed while stalled");

  // only stop, forward or reverse leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (drive_dir_i == pidm_pkg::DirStop || drive_dir_i == pidm_pkg::DirFwd ||
                     drive_dir_i == pidm_pkg::DirRev))
    else $error("illegal drive direction");

  // a stopped motor has no duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && drive_dir_i == pidm_pkg::DirStop |-> duty_i == '0)
    else $error("nonzero duty while stopped");

  // the input side only stalls behind a full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> res_valid_i && !res_ready_i)
    else $error("input stalled without output backpressure");

  // a request offered to an idle block is taken at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !res_valid_i |-> in_ready_i)
    else $error("request refused while output empty");

endmodule

bind pid_position_motor_drive pidm_checker u_pidm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .duty_i      (res_o.duty),
  .drive_dir_i (res_o.drive_dir)
);

@@ bench/pidm_drive_checker.sv @@
module pidm_drive_checker
  import pidm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [CmdWidth-1:0]     command_byte_i,
  input  logic [CountWidth-1:0]   encoder_count_i,
  input  logic                    res_valid_i,
  input  logic                    res_ready_i,
  input  logic [DutyWidth-1:0]    duty_i,
  input  logic [DirWidth-1:0]     drive_dir_i,
  output int                      mismatch_count_o,
  output int                      waiting_o
);

  localparam int DegScale    = TargetScale;
  localparam int CmdFull     = 255;
  localparam int CountPerDeg = 257;
  localparam int MaxReports  = 100;

  localparam longint SumMax = (longint'(1) <<< (SumWidth - 1)) - 1;
  localparam longint SumMin = -SumMax - 1;

  typedef struct packed {
    logic [DutyWidth-1:0] duty;
    dir_e                 dir;
  } drive_t;

  // shadow registers and controller state
  logic [GainWidth-1:0]  gain_p;
  logic [GainWidth-1:0]  gain_i;
  logic [GainWidth-1:0]  gain_d;
  logic [LimitWidth-1:0] pwm_limit;
  logic [BandWidth-1:0]  deadband;
  longint                integral;
  int                    prev_err;

  drive_t drive_due_q[$];
  drive_t due;
  int     mismatches = 0;

  // one control tick: integral, derivative, clamp, deadband
  function automatic drive_t control_tick(input logic [CmdWidth-1:0]   cmd,
                                          input logic [CountWidth-1:0] cnt);
    int     target;
    int     actual;
    int     err;
    int     deriv;
    int     mag;
    longint s;
    longint lim;
    drive_t r;
    target = (int'(cmd) * DegScale) / CmdFull;
    actual = int'(cnt) / CountPerDeg;
    err    = target - actual;
    integral = integral + err;
    if (integral > SumMax) integral = SumMax;
    if (integral < SumMin) integral = SumMin;
    deriv = err - prev_err;
    s = longint'(gain_p) * err + longint'(gain_i) * integral + longint'(gain_d) * deriv;
    lim = longint'(pwm_limit) <<< FracBits;
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    mag = (err < 0) ? -err : err;
    if (mag > int'(deadband)) begin
      if (s > 0) begin
        r.dir  = DirFwd;
        r.duty = DutyWidth'(s >>> FracBits);
      end else begin
        r.dir  = DirRev;
        r.duty = DutyWidth'((-s) >>> FracBits);
      end
    end else begin
      r.dir    = DirStop;
      r.duty   = '0;
      integral = 0;
    end
    prev_err = err;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p    = GainPReset;
      gain_i    = GainIReset;
      gain_d    = GainDReset;
      pwm_limit = PwmLimitReset;
      deadband  = DeadbandReset;
      integral  = 0;
      prev_err  = 0;
      drive_due_q.delete();
      waiting_o        <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegGainP:    gain_p    = cfg_data_i[GainWidth-1:0];
          RegGainI:    gain_i    = cfg_data_i[GainWidth-1:0];
          RegGainD:    gain_d    = cfg_data_i[GainWidth-1:0];
          RegPwmLimit: pwm_limit = cfg_data_i[LimitWidth-1:0];
          RegDeadband: deadband  = cfg_data_i[BandWidth-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        drive_due_q.push_back(control_tick(command_byte_i, encoder_count_i));
      end
      if (res_valid_i && res_ready_i) begin
        if (drive_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t unrequested result: expected none, actual duty %0d dir %0d",
                     $time, duty_i, drive_dir_i);
        end else begin
          due = drive_due_q.pop_front();
          if (duty_i !== due.duty) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t duty mismatch: expected %0d actual %0d", $time, due.duty, duty_i);
          end
          if (drive_dir_i !== due.dir) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t drive_dir mismatch: expected %0d actual %0d",
                       $time, due.dir, drive_dir_i);
          end
        end
      end
      waiting_o        <= drive_due_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

@@ bench/pid_position_motor_drive_tb.sv @@
module pid_position_motor_drive_tb;
  import pidm_pkg::*;

  // scaling used to aim encoder values at a command's target bucket
  localparam int DegScale    = TargetScale;
  localparam int CmdFull     = 255;
  localparam int CountPerDeg = 257;
  localparam int CountMax    = CmdFull * CountPerDeg;

  // pause after the last result before touching registers or ending
  localparam int SettleCycles = 4;
  localparam int NumPhases    = 8;
  localparam int PhaseItems   = 235;

  localparam logic [CfgIdxWidth-1:0] RegPastLast = CfgIdxWidth'(RegDeadband) + 1'b1;

  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  logic clk_i;
  logic rst_ni;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatch_count;
  int waiting;

  pidm_cfg_if cfg_if ();
  pidm_in_if  in_if ();
  pidm_out_if res_if ();

  pid_position_motor_drive u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  // watches all three channels, predicts every tick and compares
  pidm_drive_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_if.valid),
    .cfg_ready_i      (cfg_if.ready),
    .cfg_index_i      (cfg_if.index),
    .cfg_data_i       (cfg_if.data),
    .in_valid_i       (in_if.valid),
    .in_ready_i       (in_if.ready),
    .command_byte_i   (in_if.command_byte),
    .encoder_count_i  (in_if.encoder_count),
    .res_valid_i      (res_if.valid),
    .res_ready_i      (res_if.ready),
    .duty_i           (res_if.duty),
    .drive_dir_i      (res_if.drive_dir),
    .mismatch_count_o (mismatch_count),
    .waiting_o        (waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random backpressure at the current stall rate
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // hard stop in case a handshake never completes
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IdleNone:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IdleSender:   begin send_idle_pct = 45; stall_pct = 0;  end
      IdleReceiver: begin send_idle_pct = 0;  stall_pct = 45; end
      default:      begin send_idle_pct = 12; stall_pct = 12; end
    endcase
  endtask

  // one tick request; valid stays high afterwards so back-to-back requests
  // never see a low-then-high pair in the same step
  task automatic send_tick(input logic [CmdWidth-1:0] cmd, input logic [CountWidth-1:0] cnt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid         <= 1'b1;
    in_if.command_byte  <= cmd;
    in_if.encoder_count <= cnt;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // stop requesting and wait until every predicted result has been taken
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgDataWidth-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // full register set; unused upper data bits carry noise, and sometimes an
  // index past the last register is written too
  task automatic set_config(input logic [GainWidth-1:0]  gp,
                            input logic [GainWidth-1:0]  gi,
                            input logic [GainWidth-1:0]  gd,
                            input logic [LimitWidth-1:0] lim,
                            input logic [BandWidth-1:0]  db);
    logic [CfgDataWidth-1:0] d;
    logic [CfgIdxWidth-1:0]  junk_idx;
    write_reg(RegGainP, gp);
    write_reg(RegGainI, gi);
    write_reg(RegGainD, gd);
    d = CfgDataWidth'($urandom);
    d[LimitWidth-1:0] = lim;
    write_reg(RegPwmLimit, d);
    d = CfgDataWidth'($urandom);
    d[BandWidth-1:0] = db;
    write_reg(RegDeadband, d);
    if ($urandom_range(1) == 1) begin
      junk_idx = RegPastLast + CfgIdxWidth'($urandom_range(2));
      write_reg(junk_idx, CfgDataWidth'($urandom));
    end
    cfg_if.valid <= 1'b0;
  endtask

  // mostly tracking runs: fixed command, encoder closing in on the target
  // with jitter, so the integral builds and the deadband is crossed;
  // the rest is uncorrelated noise
  task automatic run_random(input int n, input bit pause_mid);
    int run_left;
    int run_cmd;
    int pos;
    int goal;
    int jitter;
    int r;
    bit tracking;
    run_left = 0;
    run_cmd  = 0;
    pos      = 0;
    goal     = 0;
    tracking = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) drain();
      if (run_left == 0) begin
        tracking = ($urandom_range(99) < 70);
        run_left = tracking ? $urandom_range(8, 40) : $urandom_range(1, 6);
        run_cmd  = $urandom_range(CmdFull);
        pos      = $urandom_range(CountMax);
        r        = $urandom_range(CountPerDeg - 1);
        goal     = (run_cmd * DegScale / CmdFull) * CountPerDeg + r;
      end
      run_left--;
      if (tracking) begin
        jitter = $urandom_range(600);
        pos = pos + (goal - pos) / 4 + jitter - 300;
        if (pos < 0) pos = 0;
        if (pos > CountMax) pos = CountMax;
        send_tick(run_cmd[CmdWidth-1:0], pos[CountWidth-1:0]);
      end else begin
        send_tick(CmdWidth'($urandom), CountWidth'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.command_byte  <= '0;
    in_if.encoder_count <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks under reset settings
    set_idling(IdleNone);
    send_tick(8'd0, 16'd0);                     // zero error, stop
    send_tick(8'd3, 16'd0);                     // error equals deadband, stop
    send_tick(8'd6, 16'd0);                     // just past deadband
    send_tick(8'hff, 16'd0);                    // largest positive error, clamp
    send_tick(8'hff, 16'(CountPerDeg - 1));     // top of encoder bucket zero
    send_tick(8'hff, 16'(CountPerDeg));         // first count of bucket one
    send_tick(8'd0, 16'hffff);                  // most negative error, clamp
    send_tick(8'hff, 16'hffff);
    send_tick(8'd0, 16'hfffe);
    send_tick(8'd128, 16'(45 * CountPerDeg));   // on target, integral cleared
    send_tick(8'd128, 16'(45 * CountPerDeg - 1));
    send_tick(8'd128, 16'(44 * CountPerDeg - 1));
    send_tick(8'd0, 16'(2 * CountPerDeg));      // small negative, truncation
    send_tick(8'haa, 16'haaaa);
    send_tick(8'h55, 16'h5555);

    // zero clamp: driving with zero output selects reverse at duty 0
    drain();
    set_config(GainPReset, GainIReset, GainDReset, '0, DeadbandReset);
    send_tick(8'hff, 16'd0);
    send_tick(8'd0, 16'hffff);
    send_tick(8'd6, 16'd0);

    // tiny output, truncated to zero on both signs, no deadband
    drain();
    set_config(16'd1, '0, '0, '1, '0);
    send_tick(8'd0, 16'(CountPerDeg));
    send_tick(8'd3, 16'd0);
    send_tick(8'd0, 16'd0);

    // full-scale gains
    drain();
    set_config('1, '1, '1, '1, '0);
    send_tick(8'hff, 16'd0);
    send_tick(8'd0, 16'hffff);

    // random phases, each with its own settings and one of four idling patterns
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: set_config(GainPReset, GainIReset, GainDReset, PwmLimitReset, DeadbandReset);
        1: set_config(GainWidth'($urandom), GainWidth'($urandom), GainWidth'($urandom),
                      LimitWidth'($urandom), BandWidth'($urandom_range(8)));
        2: set_config('1, '1, '1, '1, '0);
        3: set_config('0, '0, '0, '0, '1);
        4: set_config(GainWidth'($urandom), GainWidth'($urandom), GainWidth'($urandom),
                      LimitWidth'($urandom), BandWidth'($urandom));
        5: set_config(GainWidth'($urandom_range(512)), GainWidth'($urandom_range(512)),
                      GainWidth'($urandom_range(512)), LimitWidth'($urandom),
                      BandWidth'($urandom_range(3)));
        6: set_config(GainWidth'($urandom), GainWidth'($urandom), GainWidth'($urandom),
                      LimitWidth'($urandom), BandWidth'($urandom_range(2)));
        default: set_config('0, '1, '0, '1, 8'd2);
      endcase
      set_idling(idle_mode_e'(ph % 4));
      // the sender waits for a full drain halfway through one phase
      run_random(PhaseItems, ph == 1);
    end

    drain();
    if (mismatch_count == 0 && waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pidm_pkg.sv
rtl/pidm_in_if.sv
rtl/pidm_out_if.sv
rtl/pidm_cfg_if.sv
rtl/pidm_cfg_regs.sv
rtl/pidm_front.sv
rtl/pidm_core.sv
rtl/pid_position_motor_drive.sv
rtl/pidm_checker.sv
bench/pidm_drive_checker.sv
bench/pid_position_motor_drive_tb.sv
